// ===== rtl/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg
// Shared opcodes, field widths and output range limits of the rational
// arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

    // field widths of the result word
    localparam int OPC_W     = 4;
    localparam int RES_NUM_W = 32;
    localparam int RES_DEN_W = 31;

    // opcodes
    localparam logic [OPC_W-1:0] OP_ADD = 4'd0;
    localparam logic [OPC_W-1:0] OP_SUB = 4'd1;
    localparam logic [OPC_W-1:0] OP_MUL = 4'd2;
    localparam logic [OPC_W-1:0] OP_DIV = 4'd3;
    localparam logic [OPC_W-1:0] OP_EQ  = 4'd4;
    localparam logic [OPC_W-1:0] OP_NE  = 4'd5;
    localparam logic [OPC_W-1:0] OP_GT  = 4'd6;
    localparam logic [OPC_W-1:0] OP_LT  = 4'd7;
    localparam logic [OPC_W-1:0] OP_GE  = 4'd8;
    localparam logic [OPC_W-1:0] OP_LE  = 4'd9;

    // largest magnitudes that fit the result fields
    localparam logic [63:0] NUM_POS_MAX = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] NUM_NEG_MAX = 64'h0000_0000_8000_0000;
    localparam logic [63:0] DEN_MAX     = 64'h0000_0000_7FFF_FFFF;

endpackage

// ===== rtl/rau_in_if.sv =====
// ----------------------------------------------------------------------------
// rau_in_if
// Operand channel: opcode and two fractions, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rau_in_if #(
    parameter int OPERAND_WIDTH = 16
) ();
    logic                            valid;
    logic                            ready;
    logic [rau_pkg::OPC_W-1:0]       opcode;
    logic signed [OPERAND_WIDTH-1:0] a_num;
    logic signed [OPERAND_WIDTH-1:0] a_den;
    logic signed [OPERAND_WIDTH-1:0] b_num;
    logic signed [OPERAND_WIDTH-1:0] b_den;

    modport source (
        output valid, opcode, a_num, a_den, b_num, b_den,
        input  ready
    );

    modport sink (
        input  valid, opcode, a_num, a_den, b_num, b_den,
        output ready
    );
endinterface

// ===== rtl/rau_out_if.sv =====
// ----------------------------------------------------------------------------
// rau_out_if
// Result channel: reduced fraction, compare flag and error flag.
// ----------------------------------------------------------------------------
interface rau_out_if ();
    logic                                valid;
    logic                                ready;
    logic signed [rau_pkg::RES_NUM_W-1:0] res_num;
    logic [rau_pkg::RES_DEN_W-1:0]        res_den;
    logic                                cmp_true;
    logic                                error;

    modport source (
        output valid, res_num, res_den, cmp_true, error,
        input  ready
    );

    modport sink (
        input  valid, res_num, res_den, cmp_true, error,
        output ready
    );
endinterface

// ===== rtl/rau_reduce.sv =====
// ----------------------------------------------------------------------------
// rau_reduce
// Reduces a magnitude/denominator pair by their greatest common divisor:
// common factors of two are shifted out, a binary gcd loop finds the odd
// part, and a shared restoring divider step forms both quotients together.
// ----------------------------------------------------------------------------
module rau_reduce #(
    parameter int MAG_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [MAG_WIDTH-1:0] i_mag,
    input  logic [MAG_WIDTH-1:0] i_den,
    output logic                 o_done,
    output logic [MAG_WIDTH-1:0] o_mag,
    output logic [MAG_WIDTH-1:0] o_den
);
    localparam int CW = $clog2(MAG_WIDTH);

    localparam logic [1:0] R_IDLE = 2'd0;
    localparam logic [1:0] R_TWOS = 2'd1;
    localparam logic [1:0] R_GCD  = 2'd2;
    localparam logic [1:0] R_DIV  = 2'd3;

    logic [1:0]           r_state, n_state;
    logic                 r_done, n_done;
    logic [CW-1:0]        r_cnt;
    logic [MAG_WIDTH-1:0] r_x, r_y;
    logic [MAG_WIDTH-1:0] r_m, r_d;
    logic [MAG_WIDTH-1:0] r_rm, r_rd;

    // gcd step: one compare and one subtract
    logic                 w_xge;
    logic [MAG_WIDTH-1:0] w_dif;

    assign w_xge = (r_x >= r_y);
    assign w_dif = w_xge ? (r_x - r_y) : (r_y - r_x);

    // divider step for both dividends against the same divisor
    logic [MAG_WIDTH:0] w_pm, w_pd, w_sm, w_sd;
    logic               w_qm, w_qd;

    assign w_pm = {r_rm, r_m[MAG_WIDTH-1]};
    assign w_pd = {r_rd, r_d[MAG_WIDTH-1]};
    assign w_sm = w_pm - {1'b0, r_y};
    assign w_sd = w_pd - {1'b0, r_y};
    assign w_qm = ~w_sm[MAG_WIDTH];
    assign w_qd = ~w_sd[MAG_WIDTH];

    // sequencer
    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        case (r_state)
            R_IDLE: begin
                if (i_start) begin
                    n_state = R_TWOS;
                end
            end
            R_TWOS: begin
                if (r_x[0] || r_y[0]) begin
                    n_state = R_GCD;
                end
            end
            R_GCD: begin
                if (r_x == '0) begin
                    n_state = R_DIV;
                end
            end
            R_DIV: begin
                if (r_cnt == CW'(MAG_WIDTH - 1)) begin
                    n_state = R_IDLE;
                    n_done  = 1'b1;
                end
            end
            default: begin
                n_state = R_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= R_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            R_IDLE: begin
                if (i_start) begin
                    r_x <= i_mag;
                    r_y <= i_den;
                end
            end
            R_TWOS: begin
                if (!r_x[0] && !r_y[0]) begin
                    r_x <= r_x >> 1;
                    r_y <= r_y >> 1;
                end else begin
                    r_m <= r_x;
                    r_d <= r_y;
                end
            end
            R_GCD: begin
                if (r_x == '0) begin
                    r_rm  <= '0;
                    r_rd  <= '0;
                    r_cnt <= '0;
                end else if (!r_x[0]) begin
                    r_x <= r_x >> 1;
                end else if (!r_y[0]) begin
                    r_y <= r_y >> 1;
                end else if (w_xge) begin
                    r_x <= w_dif >> 1;
                end else begin
                    r_y <= w_dif >> 1;
                end
            end
            R_DIV: begin
                r_rm  <= w_qm ? w_sm[MAG_WIDTH-1:0] : w_pm[MAG_WIDTH-1:0];
                r_rd  <= w_qd ? w_sd[MAG_WIDTH-1:0] : w_pd[MAG_WIDTH-1:0];
                r_m   <= {r_m[MAG_WIDTH-2:0], w_qm};
                r_d   <= {r_d[MAG_WIDTH-2:0], w_qd};
                r_cnt <= r_cnt + 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_done = r_done;
    assign o_mag  = r_m;
    assign o_den  = r_d;

`ifndef SYNTHESIS
    // divisor never collapses to zero once the loop runs
    a_divisor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == R_GCD || r_state == R_DIV) |-> (r_y != '0))
        else $error("rau_reduce: gcd divisor reached zero");

    // a new job only starts while idle
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == R_IDLE))
        else $error("rau_reduce: start while busy");

    // done is a single-cycle pulse
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("rau_reduce: done held high");
`endif

endmodule

// ===== rtl/rational_arithmetic_unit.sv =====
// Sequence: errors and unused opcodes go from accept straight to the result stage;
// compares run the multiplier steps and the combine stage; add/sub/mul/div also run
// the gcd reducer (shift-out of common twos, binary gcd loop, divider) unless the
// combined magnitude is zero.
// Throughput: one word in flight; the next is accepted once the result is loaded.
// Reset: i_rst_n is synchronous, active low, and clears the sequencer and output valid.
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Adds, subtracts, multiplies, divides or compares two fractions; arithmetic
// results are reduced by the gcd with the sign on the numerator.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rau_in_if.sink      i_in,
    rau_out_if.source   o_res
);
    localparam int W = OPERAND_WIDTH;
    localparam int M = 2 * OPERAND_WIDTH;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_COMB = 3'd2;
    localparam logic [2:0] S_RED  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    // multiplier step codes
    localparam logic [1:0] P_AN_BD = 2'd0;
    localparam logic [1:0] P_BN_AD = 2'd1;
    localparam logic [1:0] P_AD_BD = 2'd2;
    localparam logic [1:0] P_AN_BN = 2'd3;

    logic [2:0]                  r_state, n_state;
    logic [1:0]                  r_step, n_step;
    logic                        r_ovalid, n_ovalid;
    logic [rau_pkg::OPC_W-1:0]   r_op;
    logic [W-1:0]                r_an, r_ad, r_bn, r_bd;
    logic                        r_aneg, r_bneg;
    logic [M-1:0]                r_p [4];
    logic [M-1:0]                r_m, r_d;
    logic                        r_neg, r_cmp, r_err;
    logic signed [rau_pkg::RES_NUM_W-1:0] r_onum;
    logic [rau_pkg::RES_DEN_W-1:0]        r_oden;
    logic                        r_ocmp, r_oerr;

    // operand normalization: sign moves to the numerator
    logic         w_accept;
    logic [W-1:0] w_anm, w_adm, w_bnm, w_bdm;
    logic         w_aneg, w_bneg, w_zero_den, w_div0, w_op_ok;

    assign w_accept = i_in.valid && i_in.ready;
    assign w_anm  = i_in.a_num[W-1] ? (~i_in.a_num + 1'b1) : i_in.a_num;
    assign w_adm  = i_in.a_den[W-1] ? (~i_in.a_den + 1'b1) : i_in.a_den;
    assign w_bnm  = i_in.b_num[W-1] ? (~i_in.b_num + 1'b1) : i_in.b_num;
    assign w_bdm  = i_in.b_den[W-1] ? (~i_in.b_den + 1'b1) : i_in.b_den;
    assign w_aneg = (i_in.a_num != '0) && (i_in.a_num[W-1] ^ i_in.a_den[W-1]);
    assign w_bneg = (i_in.b_num != '0) && (i_in.b_num[W-1] ^ i_in.b_den[W-1]);
    assign w_zero_den = (i_in.a_den == '0) || (i_in.b_den == '0);
    assign w_div0     = (i_in.opcode == rau_pkg::OP_DIV) && (i_in.b_num == '0);
    assign w_op_ok    = (i_in.opcode <= rau_pkg::OP_LE);

    // shared multiplier
    logic [W-1:0] w_ma, w_mb;
    logic [M-1:0] w_prod;

    always_comb begin
        case (r_step)
            P_AN_BD: begin
                w_ma = r_an;
                w_mb = r_bd;
            end
            P_BN_AD: begin
                w_ma = r_bn;
                w_mb = r_ad;
            end
            P_AD_BD: begin
                w_ma = r_ad;
                w_mb = r_bd;
            end
            default: begin
                w_ma = r_an;
                w_mb = r_bn;
            end
        endcase
    end

    assign w_prod = w_ma * w_mb;

    // combine products: add/sub magnitude, mul/div product pick, or exact cross compare
    logic               c_n2, c_ge, c_neg, c_cmp, c_is_cmp, c_reduce;
    logic [M-1:0]       c_mag, c_den;
    logic signed [M:0]  c_pl, c_pr, c_l, c_r;

    assign c_n2 = r_bneg ^ (r_op == rau_pkg::OP_SUB);
    assign c_ge = (r_p[P_AN_BD] >= r_p[P_BN_AD]);
    assign c_pl = {1'b0, r_p[P_AN_BD]};
    assign c_pr = {1'b0, r_p[P_BN_AD]};
    assign c_l  = r_aneg ? -c_pl : c_pl;
    assign c_r  = r_bneg ? -c_pr : c_pr;
    assign c_is_cmp = (r_op >= rau_pkg::OP_EQ);

    always_comb begin
        c_mag = '0;
        c_den = r_p[P_AD_BD];
        c_neg = 1'b0;
        c_cmp = 1'b0;
        case (r_op)
            rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
                if (r_aneg == c_n2) begin
                    c_mag = r_p[P_AN_BD] + r_p[P_BN_AD];
                    c_neg = r_aneg;
                end else if (c_ge) begin
                    c_mag = r_p[P_AN_BD] - r_p[P_BN_AD];
                    c_neg = r_aneg;
                end else begin
                    c_mag = r_p[P_BN_AD] - r_p[P_AN_BD];
                    c_neg = c_n2;
                end
            end
            rau_pkg::OP_MUL: begin
                c_mag = r_p[P_AN_BN];
                c_neg = r_aneg ^ r_bneg;
            end
            rau_pkg::OP_DIV: begin
                c_mag = r_p[P_AN_BD];
                c_den = r_p[P_BN_AD];
                c_neg = r_aneg ^ r_bneg;
            end
            rau_pkg::OP_EQ: c_cmp = (c_l == c_r);
            rau_pkg::OP_NE: c_cmp = (c_l != c_r);
            rau_pkg::OP_GT: c_cmp = (c_l > c_r);
            rau_pkg::OP_LT: c_cmp = (c_l < c_r);
            rau_pkg::OP_GE: c_cmp = (c_l >= c_r);
            rau_pkg::OP_LE: c_cmp = (c_l <= c_r);
            default: begin
            end
        endcase
    end

    assign c_reduce = !c_is_cmp && (c_mag != '0);

    // gcd reduction
    logic         w_red_start, w_red_done;
    logic [M-1:0] w_red_mag, w_red_den;

    assign w_red_start = (r_state == S_COMB) && c_reduce;

    rau_reduce #(
        .MAG_WIDTH (M)
    ) u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_red_start),
        .i_mag   (c_mag),
        .i_den   (c_den),
        .o_done  (w_red_done),
        .o_mag   (w_red_mag),
        .o_den   (w_red_den)
    );

    // range check and result formatting
    logic                                f_load, f_ovf, f_err;
    logic [rau_pkg::RES_NUM_W-1:0]       f_num;

    assign f_load = (r_state == S_FIN) && (!r_ovalid || o_res.ready);
    assign f_ovf  = (64'(r_d) > rau_pkg::DEN_MAX) ||
                    (64'(r_m) > (r_neg ? rau_pkg::NUM_NEG_MAX : rau_pkg::NUM_POS_MAX));
    assign f_err  = r_err || f_ovf;
    assign f_num  = rau_pkg::RES_NUM_W'(r_m);

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_ovalid = r_ovalid && !o_res.ready;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_step = P_AN_BD;
                    if (w_zero_den || w_div0 || !w_op_ok) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                n_step = r_step + 1'b1;
                if (r_step == P_AN_BN) begin
                    n_state = S_COMB;
                end
            end
            S_COMB: begin
                n_state = c_reduce ? S_RED : S_FIN;
            end
            S_RED: begin
                if (w_red_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (f_load) begin
                    n_state  = S_IDLE;
                    n_ovalid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= P_AN_BD;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_ovalid <= n_ovalid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_op   <= i_in.opcode;
                    r_an   <= w_anm;
                    r_ad   <= w_adm;
                    r_bn   <= w_bnm;
                    r_bd   <= w_bdm;
                    r_aneg <= w_aneg;
                    r_bneg <= w_bneg;
                    r_err  <= w_zero_den || w_div0;
                    r_cmp  <= 1'b0;
                    r_neg  <= 1'b0;
                    r_m    <= '0;
                    r_d    <= M'(1);
                end
            end
            S_MUL: begin
                r_p[r_step] <= w_prod;
            end
            S_COMB: begin
                r_neg <= c_neg;
                r_cmp <= c_cmp;
                r_m   <= '0;
                r_d   <= M'(1);
            end
            S_RED: begin
                if (w_red_done) begin
                    r_m <= w_red_mag;
                    r_d <= w_red_den;
                end
            end
            S_FIN: begin
                if (f_load) begin
                    r_onum <= f_err ? '0 : (r_neg ? -f_num : f_num);
                    r_oden <= f_err ? rau_pkg::RES_DEN_W'(1) : rau_pkg::RES_DEN_W'(r_d);
                    r_ocmp <= r_cmp && !f_err;
                    r_oerr <= f_err;
                end
            end
            default: begin
            end
        endcase
    end

    assign i_in.ready     = (r_state == S_IDLE);
    assign o_res.valid    = r_ovalid;
    assign o_res.res_num  = r_onum;
    assign o_res.res_den  = r_oden;
    assign o_res.cmp_true = r_ocmp;
    assign o_res.error    = r_oerr;

`ifndef SYNTHESIS
    // an error word always carries 0/1 and no compare flag
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.error) |->
            (o_res.res_num == '0 && o_res.res_den == rau_pkg::RES_DEN_W'(1) &&
             !o_res.cmp_true))
        else $error("rational_arithmetic_unit: error word not 0/1");

    // denominator of a valid word is never zero
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.res_den != '0))
        else $error("rational_arithmetic_unit: zero result denominator");

    // an accepted word always leaves idle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE))
        else $error("rational_arithmetic_unit: accept did not start work");

    // reducer finishes only while the sequencer waits on it
    a_red_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_red_done |-> (r_state == S_RED))
        else $error("rational_arithmetic_unit: stray reducer done");
`endif

endmodule
